### rtl/core/svpwm_phase_voltages_defines.svh
// ---------------------------------------------------------------------------
// SVPWM assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SVPWM_PHASE_VOLTAGES_DEFINES_SVH
`define SVPWM_PHASE_VOLTAGES_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SVPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define SVPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/svpwm_pkg.sv
// ---------------------------------------------------------------------------
// SVPWM package
// Widths, fixed-point constants, sector codes and the sine table.
// ---------------------------------------------------------------------------
package svpwm_pkg;

  // Angle resolution: a full turn is 2**ANGLE_BITS.
  localparam int ANGLE_BITS  = 16;
  localparam int VOLT_W      = 16;

  // Angle within a sector as a 17-bit fraction of pi/3 (65536 is pi/3).
  localparam int FRAC_W      = 17;
  localparam int FRAC_WIDE_W = ANGLE_BITS + FRAC_W;
  localparam int FRAC_LSH    = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int FRAC_RSH    = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN       = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));
  localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = ANGLE_BITS'(64'd3 << (ANGLE_BITS - 2));
  localparam logic [ANGLE_BITS:0]   FULL_TURN          = (ANGLE_BITS + 1)'(64'd1 << ANGLE_BITS);

  // Sine interpolation.
  localparam int SINE_W          = 16;
  localparam int DELTA_W         = 12;
  localparam int INTERP_W        = 11;
  localparam int IDX_W           = FRAC_W - INTERP_W;
  localparam int INTERP_PROD_W   = DELTA_W + INTERP_W;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(32);
  localparam logic [INTERP_PROD_W-1:0] INTERP_ROUND = INTERP_PROD_W'(1) << (INTERP_W - 1);

  // sqrt3 scaling in Q16.
  localparam int SQRT3_W         = 17;
  localparam int SQRT3_FRAC_BITS = 16;
  localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;
  localparam int KP_W            = SINE_W + SQRT3_W;
  localparam logic [KP_W-1:0] K_ROUND = KP_W'(1) << (SQRT3_FRAC_BITS - 1);
  localparam int K_W             = 17;
  localparam int KM_W            = K_W + VOLT_W;

  // Divider and active time.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STAGES = DIVIDEND_W;
  localparam int ACT_LAT    = 4 + DIV_STAGES;

  // Duties in Q17.
  localparam int DUTY_W         = 18;
  localparam int DUTY_FRAC_BITS = 17;
  localparam int SUM_W          = 35;
  localparam logic [DUTY_W-1:0]       DUTY_ONE    = 18'd131072;
  localparam logic signed [SUM_W-1:0] DUTY_ONE_S  = 35'sd131072;
  localparam logic signed [SUM_W-1:0] DUTY_HALF_S = 35'sd65536;
  localparam int PROD_W      = DUTY_W + VOLT_W;
  localparam int PROD_EXT_W  = PROD_W + 1;
  localparam logic [PROD_EXT_W-1:0] VOLT_ROUND = PROD_EXT_W'(1) << (DUTY_FRAC_BITS - 1);

  localparam logic [VOLT_W-1:0] SUPPLY_RESET = 16'd3072;

  // Sector codes as they come out of the angle split (shown as code plus one).
  localparam int SECTOR_W = 3;
  localparam logic [SECTOR_W-1:0] SECT_1 = 3'd0;
  localparam logic [SECTOR_W-1:0] SECT_2 = 3'd1;
  localparam logic [SECTOR_W-1:0] SECT_3 = 3'd2;
  localparam logic [SECTOR_W-1:0] SECT_4 = 3'd3;
  localparam logic [SECTOR_W-1:0] SECT_5 = 3'd4;
  localparam logic [SECTOR_W-1:0] SECT_6 = 3'd5;

  // Q16 sin(k*pi/96), k = 0..32.
  function automatic logic [SINE_W-1:0] sine_q16(logic [IDX_W-1:0] idx);
    case (idx)
      0:       return 16'd0;
      1:       return 16'd2144;
      2:       return 16'd4286;
      3:       return 16'd6424;
      4:       return 16'd8554;
      5:       return 16'd10676;
      6:       return 16'd12785;
      7:       return 16'd14882;
      8:       return 16'd16962;
      9:       return 16'd19024;
      10:      return 16'd21066;
      11:      return 16'd23085;
      12:      return 16'd25080;
      13:      return 16'd27047;
      14:      return 16'd28986;
      15:      return 16'd30893;
      16:      return 16'd32768;
      17:      return 16'd34610;
      18:      return 16'd36410;
      19:      return 16'd38173;
      20:      return 16'd39896;
      21:      return 16'd41576;
      22:      return 16'd43211;
      23:      return 16'd44800;
      24:      return 16'd46341;
      25:      return 16'd47832;
      26:      return 16'd49273;
      27:      return 16'd50660;
      28:      return 16'd51993;
      29:      return 16'd53271;
      30:      return 16'd54491;
      31:      return 16'd55653;
      32:      return 16'd56756;
      default: return 16'd56756;
    endcase
  endfunction

  // Brings an angle of ANGLE_BITS resolution to the 17-bit sector fraction.
  function automatic logic [FRAC_W-1:0] frac_q16(logic [ANGLE_BITS:0] u);
    logic [FRAC_WIDE_W-1:0] w;
    w = FRAC_WIDE_W'(u) << FRAC_LSH;
    return FRAC_W'(w >> FRAC_RSH);
  endfunction

endpackage

### rtl/core/svpwm_div.sv
// ---------------------------------------------------------------------------
// SVPWM pipelined divider
// Restoring unsigned divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module svpwm_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [svpwm_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [svpwm_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic [svpwm_pkg::DIVIDEND_W-1:0]   quotient_o
);
  import svpwm_pkg::*;

  // The divisor is taken straight from the port; the user must change it only
  // while the pipeline is empty, which the divider itself does not enforce.
  logic [DIVIDEND_W-1:0] num_q [DIV_STAGES-1];
  logic [DIVISOR_W-1:0]  rem_q [DIV_STAGES-1];
  logic [DIVIDEND_W-1:0] quo_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIVIDEND_W-1:0] num_in;
    logic [DIVIDEND_W-1:0] quo_in;
    logic [DIVISOR_W-1:0]  rem_in;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  take;

    if (g == 0) begin : g_first
      assign num_in = dividend_i;
      assign quo_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_q[g-1];
      assign quo_in = quo_q[g-1];
      assign rem_in = rem_q[g-1];
    end

    assign trial = {rem_in, num_in[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign take  = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[g] <= {quo_in[DIVIDEND_W-2:0], take};
      end
    end

    if (g < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[g] <= {num_in[DIVIDEND_W-2:0], 1'b0};
          rem_q[g] <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
      end
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

### rtl/core/svpwm_active_time.sv
// ---------------------------------------------------------------------------
// SVPWM active vector time
// floor(sqrt3 * sin(frac * pi/3) * mag / divisor) as a Q16 duty, pipelined.
// ---------------------------------------------------------------------------
module svpwm_active_time (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [svpwm_pkg::FRAC_W-1:0]       frac_i,
  input  logic [svpwm_pkg::VOLT_W-1:0]       mag_i,
  input  logic [svpwm_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic [svpwm_pkg::DIVIDEND_W-1:0]   time_o
);
  import svpwm_pkg::*;

  logic [IDX_W-1:0]         idx;
  logic [SINE_W-1:0]        base_d;
  logic [DELTA_W-1:0]       delta_d;
  logic [INTERP_PROD_W-1:0] interp;
  logic [K_W-1:0]           k_val;

  logic [SINE_W-1:0]     d_base_q;
  logic [DELTA_W-1:0]    d_delta_q;
  logic [INTERP_W-1:0]   d_ofs_q;
  logic [VOLT_W-1:0]     d_mag_q;
  logic [SINE_W-1:0]     e_sine_q;
  logic [VOLT_W-1:0]     e_mag_q;
  logic [KP_W-1:0]       f_prod_q;
  logic [VOLT_W-1:0]     f_mag_q;
  logic [DIVIDEND_W-1:0] g_dividend_q;

  // Table step; past the last entry the sine stays at its end value.
  assign idx = frac_i[FRAC_W-1:INTERP_W];

  always_comb begin
    if (idx >= IDX_TOP) begin
      base_d  = sine_q16(IDX_TOP);
      delta_d = '0;
    end else begin
      base_d  = sine_q16(idx);
      delta_d = DELTA_W'(sine_q16(idx + IDX_W'(1)) - sine_q16(idx));
    end
  end

  assign interp = INTERP_PROD_W'(INTERP_PROD_W'(d_delta_q) * INTERP_PROD_W'(d_ofs_q))
                  + INTERP_ROUND;
  assign k_val  = K_W'((f_prod_q + K_ROUND) >> SQRT3_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_base_q     <= base_d;
      d_delta_q    <= delta_d;
      d_ofs_q      <= frac_i[INTERP_W-1:0];
      d_mag_q      <= mag_i;
      e_sine_q     <= d_base_q + SINE_W'(interp >> INTERP_W);
      e_mag_q      <= d_mag_q;
      f_prod_q     <= KP_W'(e_sine_q) * KP_W'(SQRT3_Q16);
      f_mag_q      <= e_mag_q;
      g_dividend_q <= DIVIDEND_W'(KM_W'(k_val) * KM_W'(f_mag_q));
    end
  end

  svpwm_div u_div (
    .clk_i      (clk_i),
    .en_i       (en_i),
    .dividend_i (g_dividend_q),
    .divisor_i  (divisor_i),
    .quotient_o (time_o)
  );

endmodule

### rtl/core/svpwm_phase_voltages.sv
// ---------------------------------------------------------------------------
// SVPWM phase voltages
// Three phase voltages, sector and clip flag from a quadrature voltage and
// an electrical angle.
// ---------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled and
// returns one result word for each, in order: three stages split the angle,
// two parallel active-time channels follow (sine, sqrt3 scaling and a
// 32-stage divider by the supply register), and three stages build, scale
// and register the duties. A stall while a finished word waits at the output
// freezes the whole pipeline, so the input stalls in the same cycle. The
// supply register may be written only while no word is in flight.
`include "svpwm_phase_voltages_defines.svh"

module svpwm_phase_voltages (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [svpwm_pkg::VOLT_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [svpwm_pkg::VOLT_W-1:0] uq_volts_i,
  input  logic [15:0]                         elec_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [svpwm_pkg::VOLT_W-1:0]        phase_a_volts_o,
  output logic [svpwm_pkg::VOLT_W-1:0]        phase_b_volts_o,
  output logic [svpwm_pkg::VOLT_W-1:0]        phase_c_volts_o,
  output logic [svpwm_pkg::SECTOR_W-1:0]      sector_number_o,
  output logic                                clipped_o
);
  import svpwm_pkg::*;

  logic                  adv;
  logic [VOLT_W-1:0]     supply_q;
  logic [DIVISOR_W-1:0]  divisor;

  logic                  neg;
  logic [VOLT_W-1:0]     uq_u;
  logic [VOLT_W-1:0]     mag_d;
  logic [ANGLE_BITS-1:0] ang_d;
  logic [ANGLE_BITS+2:0] ang6;

  logic                  a_valid_q;
  logic [VOLT_W-1:0]     a_mag_q;
  logic [ANGLE_BITS-1:0] a_ang_q;

  logic                  b_valid_q;
  logic [VOLT_W-1:0]     b_mag_q;
  logic [SECTOR_W-1:0]   b_sector_q;
  logic [ANGLE_BITS-1:0] b_rem_q;

  logic                  c_valid_q;
  logic [VOLT_W-1:0]     c_mag_q;
  logic [SECTOR_W-1:0]   c_sector_q;
  logic [FRAC_W-1:0]     c_frac1_q;
  logic [FRAC_W-1:0]     c_frac2_q;

  logic                  lat_valid_q  [ACT_LAT];
  logic [SECTOR_W-1:0]   lat_sector_q [ACT_LAT];

  logic [DIVIDEND_W-1:0] t1;
  logic [DIVIDEND_W-1:0] t2;

  logic signed [SUM_W-1:0] t1s, t2s, full, lead, lag, zero;
  logic signed [SUM_W-1:0] duty_raw [3];
  logic [DUTY_W-1:0]       duty_d   [3];
  logic [2:0]              clip_bits;

  logic                  h_valid_q;
  logic [SECTOR_W-1:0]   h_sector_q;
  logic                  h_clip_q;
  logic [DUTY_W-1:0]     h_duty_q [3];

  logic                  i_valid_q;
  logic [SECTOR_W-1:0]   i_sector_q;
  logic                  i_clip_q;
  logic [PROD_W-1:0]     i_prod_q [3];

  logic                  out_valid_q;
  logic [VOLT_W-1:0]     volts_q [3];
  logic [SECTOR_W-1:0]   sector_q;
  logic                  clip_q;

  // The whole pipeline moves unless a finished word is held at the output.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign divisor    = (supply_q == '0) ? DIVISOR_W'(1) : supply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RESET;
    end else if (cfg_we_i) begin
      supply_q <= cfg_wdata_i;
    end
  end

  // A negative voltage turns the vector by half a turn; the quarter turn
  // moves the q axis onto the reference.
  assign neg   = uq_volts_i[VOLT_W-1];
  assign uq_u  = VOLT_W'(uq_volts_i);
  assign mag_d = neg ? VOLT_W'(~uq_u + VOLT_W'(1)) : uq_u;
  assign ang_d = ANGLE_BITS'(elec_angle_i) + (neg ? THREE_QUARTER_TURN : QUARTER_TURN);

  assign ang6  = (ANGLE_BITS + 3)'({a_ang_q, 2'b00}) + (ANGLE_BITS + 3)'({a_ang_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_mag_q    <= mag_d;
      a_ang_q    <= ang_d;
      b_mag_q    <= a_mag_q;
      b_sector_q <= ang6[ANGLE_BITS+2:ANGLE_BITS];
      b_rem_q    <= ang6[ANGLE_BITS-1:0];
      c_mag_q    <= b_mag_q;
      c_sector_q <= b_sector_q;
      c_frac1_q  <= frac_q16(FULL_TURN - {1'b0, b_rem_q});
      c_frac2_q  <= frac_q16({1'b0, b_rem_q});
    end
  end

  svpwm_active_time u_t1 (
    .clk_i     (clk_i),
    .en_i      (adv),
    .frac_i    (c_frac1_q),
    .mag_i     (c_mag_q),
    .divisor_i (divisor),
    .time_o    (t1)
  );

  svpwm_active_time u_t2 (
    .clk_i     (clk_i),
    .en_i      (adv),
    .frac_i    (c_frac2_q),
    .mag_i     (c_mag_q),
    .divisor_i (divisor),
    .time_o    (t2)
  );

  // Valid and sector ride alongside the active-time channels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < ACT_LAT; n++) begin
        lat_valid_q[n] <= 1'b0;
      end
    end else if (adv) begin
      lat_valid_q[0] <= c_valid_q;
      for (int n = 1; n < ACT_LAT; n++) begin
        lat_valid_q[n] <= lat_valid_q[n-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat_sector_q[0] <= c_sector_q;
      for (int n = 1; n < ACT_LAT; n++) begin
        lat_sector_q[n] <= lat_sector_q[n-1];
      end
    end
  end

  // Duties in Q17 with half the zero time on each side.
  always_comb begin
    t1s  = $signed(SUM_W'(t1));
    t2s  = $signed(SUM_W'(t2));
    full = DUTY_HALF_S + t1s + t2s;
    lead = DUTY_HALF_S + t1s - t2s;
    lag  = DUTY_HALF_S + t2s - t1s;
    zero = DUTY_HALF_S - t1s - t2s;
    case (lat_sector_q[ACT_LAT-1])
      SECT_1: begin
        duty_raw[0] = full; duty_raw[1] = lag;  duty_raw[2] = zero;
      end
      SECT_2: begin
        duty_raw[0] = lead; duty_raw[1] = full; duty_raw[2] = zero;
      end
      SECT_3: begin
        duty_raw[0] = zero; duty_raw[1] = full; duty_raw[2] = lag;
      end
      SECT_4: begin
        duty_raw[0] = zero; duty_raw[1] = lead; duty_raw[2] = full;
      end
      SECT_5: begin
        duty_raw[0] = lag;  duty_raw[1] = zero; duty_raw[2] = full;
      end
      default: begin
        duty_raw[0] = full; duty_raw[1] = zero; duty_raw[2] = lead;
      end
    endcase
    for (int p = 0; p < 3; p++) begin
      if (duty_raw[p][SUM_W-1]) begin
        duty_d[p]    = '0;
        clip_bits[p] = 1'b1;
      end else if (duty_raw[p] > DUTY_ONE_S) begin
        duty_d[p]    = DUTY_ONE;
        clip_bits[p] = 1'b1;
      end else begin
        duty_d[p]    = DUTY_W'(duty_raw[p]);
        clip_bits[p] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q   <= 1'b0;
      i_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      h_valid_q   <= lat_valid_q[ACT_LAT-1];
      i_valid_q   <= h_valid_q;
      out_valid_q <= i_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_sector_q <= lat_sector_q[ACT_LAT-1];
      h_clip_q   <= |clip_bits;
      i_sector_q <= h_sector_q;
      i_clip_q   <= h_clip_q;
      sector_q   <= SECTOR_W'(i_sector_q + SECTOR_W'(1));
      clip_q     <= i_clip_q;
      for (int p = 0; p < 3; p++) begin
        h_duty_q[p] <= duty_d[p];
        i_prod_q[p] <= PROD_W'(h_duty_q[p]) * PROD_W'(supply_q);
        volts_q[p]  <= VOLT_W'((PROD_EXT_W'(i_prod_q[p]) + VOLT_ROUND) >> DUTY_FRAC_BITS);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_a_volts_o = volts_q[0];
  assign phase_b_volts_o = volts_q[1];
  assign phase_c_volts_o = volts_q[2];
  assign sector_number_o = sector_q;
  assign clipped_o       = clip_q;

  // The sector code must stay in range, and sectors 1 to 4 must keep their phase order.
  `SVPWM_ASSERT(a_sector_range, !out_valid_q || (sector_q != '0 && sector_q != '1), "sector out of range")
  `SVPWM_ASSERT_IMP(a_order_s1, h_valid_q && h_sector_q == SECT_1, h_duty_q[0] >= h_duty_q[1] && h_duty_q[1] >= h_duty_q[2], "sector 1 phase order")
  `SVPWM_ASSERT_IMP(a_order_s2, h_valid_q && h_sector_q == SECT_2, h_duty_q[1] >= h_duty_q[0] && h_duty_q[0] >= h_duty_q[2], "sector 2 phase order")
  `SVPWM_ASSERT_IMP(a_order_s3, h_valid_q && h_sector_q == SECT_3, h_duty_q[1] >= h_duty_q[2] && h_duty_q[2] >= h_duty_q[0], "sector 3 phase order")
  `SVPWM_ASSERT_IMP(a_order_s4, h_valid_q && h_sector_q == SECT_4, h_duty_q[2] >= h_duty_q[1] && h_duty_q[1] >= h_duty_q[0], "sector 4 phase order")

endmodule

### tb/tb_svpwm_phase_voltages.sv
// ---------------------------------------------------------------------------
// SVPWM phase voltages testbench
// Drives quadrature voltage and angle words through the block under random
// sender gaps and receiver stalls. A fixed-point predictor computes the
// three phase voltages, the sector and the clip flag for every accepted word.
// Each output word is checked against the oldest prediction. The supply
// register is swept over its extremes and random values between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_svpwm_phase_voltages;
  import svpwm_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam longint unsigned TURN = 64'd1 << AB;
  localparam longint unsigned ROOT3_Q16 = 64'd113512;
  localparam longint DUTY_FULL = 131072;
  localparam int PIPE_SETTLE = 48;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [VOLT_W-1:0]   phase_a;
    logic [VOLT_W-1:0]   phase_b;
    logic [VOLT_W-1:0]   phase_c;
    logic [SECTOR_W-1:0] sector;
    logic                clip;
  } phase_word_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [VOLT_W-1:0]          cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [VOLT_W-1:0]   uq_volts_i;
  logic [15:0]                elec_angle_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [VOLT_W-1:0]          phase_a_volts_o;
  logic [VOLT_W-1:0]          phase_b_volts_o;
  logic [VOLT_W-1:0]          phase_c_volts_o;
  logic [SECTOR_W-1:0]        sector_number_o;
  logic                       clipped_o;

  phase_word_t       expected_phases [$];
  logic [VOLT_W-1:0] supply_mirror;
  int                mismatch_count;
  int                burst_left;

  // Q16 sin(k*pi/96), k = 0..32.
  int unsigned sine_pts [33] = '{
    0, 2144, 4286, 6424, 8554, 10676, 12785, 14882,
    16962, 19024, 21066, 23085, 25080, 27047, 28986, 30893,
    32768, 34610, 36410, 38173, 39896, 41576, 43211, 44800,
    46341, 47832, 49273, 50660, 51993, 53271, 54491, 55653,
    56756
  };

  svpwm_phase_voltages dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .uq_volts_i     (uq_volts_i),
    .elec_angle_i   (elec_angle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .phase_a_volts_o(phase_a_volts_o),
    .phase_b_volts_o(phase_b_volts_o),
    .phase_c_volts_o(phase_c_volts_o),
    .sector_number_o(sector_number_o),
    .clipped_o      (clipped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_svpwm_phase_voltages: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Angle of AB bits brought to a 17-bit fraction of pi/3.
  function automatic longint unsigned sector_frac(longint unsigned u);
    if (AB >= 16) begin
      return u >> (AB - 16);
    end
    return u << (16 - AB);
  endfunction

  function automatic longint unsigned interp_sine(longint unsigned f);
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    idx = f >> 11;
    rem = f & 64'd2047;
    if (idx >= 32) begin
      return sine_pts[32];
    end
    lo = sine_pts[idx];
    hi = sine_pts[idx + 1];
    return lo + (((hi - lo) * rem + 64'd1024) >> 11);
  endfunction

  function automatic longint vector_time(longint unsigned f, longint unsigned mag,
                                         longint unsigned vs);
    longint unsigned k;
    k = (interp_sine(f) * ROOT3_Q16 + 64'd32768) >> 16;
    return longint'((k * mag) / vs);
  endfunction

  function automatic phase_word_t predict_phases(logic signed [VOLT_W-1:0] uq,
                                                 logic [15:0] angle,
                                                 logic [VOLT_W-1:0] vsupply);
    longint unsigned mag;
    longint unsigned ang;
    longint unsigned a6;
    longint unsigned s0;
    longint unsigned r;
    longint unsigned vs;
    longint          t1;
    longint          t2;
    longint          full;
    longint          lead;
    longint          lag;
    longint          zero;
    longint          duty [3];
    logic [VOLT_W-1:0] volts [3];
    phase_word_t     w;
    w = '0;
    mag = {48'd0, uq};
    ang = {48'd0, angle} & (TURN - 1);
    // A negative request points the other way: half a turn on, magnitude kept.
    if (uq[VOLT_W-1]) begin
      mag = 64'd65536 - mag;
      ang = ang + (TURN >> 1);
    end
    ang = (ang + (TURN >> 2)) & (TURN - 1);
    a6 = ang * 6;
    s0 = a6 >> AB;
    r = a6 - (s0 << AB);
    vs = (vsupply == '0) ? 64'd1 : {48'd0, vsupply};
    t1 = vector_time(sector_frac(TURN - r), mag, vs);
    t2 = vector_time(sector_frac(r), mag, vs);
    full = 65536 + t1 + t2;
    lead = 65536 + t1 - t2;
    lag  = 65536 + t2 - t1;
    zero = 65536 - t1 - t2;
    case (SECTOR_W'(s0))
      SECT_1: begin
        duty[0] = full; duty[1] = lag;  duty[2] = zero;
      end
      SECT_2: begin
        duty[0] = lead; duty[1] = full; duty[2] = zero;
      end
      SECT_3: begin
        duty[0] = zero; duty[1] = full; duty[2] = lag;
      end
      SECT_4: begin
        duty[0] = zero; duty[1] = lead; duty[2] = full;
      end
      SECT_5: begin
        duty[0] = lag;  duty[1] = zero; duty[2] = full;
      end
      default: begin
        duty[0] = full; duty[1] = zero; duty[2] = lead;
      end
    endcase
    for (int p = 0; p < 3; p++) begin
      if (duty[p] < 0) begin
        duty[p] = 0;
        w.clip = 1'b1;
      end else if (duty[p] > DUTY_FULL) begin
        duty[p] = DUTY_FULL;
        w.clip = 1'b1;
      end
      volts[p] = VOLT_W'((unsigned'(duty[p]) * {48'd0, vsupply} + 64'd65536) >> 17);
    end
    w.phase_a = volts[0];
    w.phase_b = volts[1];
    w.phase_c = volts[2];
    w.sector  = SECTOR_W'(s0 + 1);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  initial begin
    phase_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_phases.size() == 0) begin
          report_mismatch("unexpected word, sector", sector_number_o, 0);
        end else begin
          want = expected_phases.pop_front();
          if (phase_a_volts_o !== want.phase_a)
            report_mismatch("phase_a_volts", phase_a_volts_o, want.phase_a);
          if (phase_b_volts_o !== want.phase_b)
            report_mismatch("phase_b_volts", phase_b_volts_o, want.phase_b);
          if (phase_c_volts_o !== want.phase_c)
            report_mismatch("phase_c_volts", phase_c_volts_o, want.phase_c);
          if (sector_number_o !== want.sector)
            report_mismatch("sector_number", sector_number_o, want.sector);
          if (clipped_o !== want.clip)
            report_mismatch("clipped", clipped_o, want.clip);
        end
      end
    end
  end

  // The receiver picks a new stall behavior at random after each span of random length.
  initial begin
    stall_mode_e mode;
    int          span;
    int          tick;
    out_stall_i <= 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
          default:        out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sends one word. The sender runs in bursts; between bursts valid may drop for
  // a random gap while the payload carries noise.
  task automatic send_word(input logic signed [VOLT_W-1:0] uq, input logic [15:0] angle);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_valid_i   <= 1'b0;
        uq_volts_i   <= VOLT_W'($urandom);
        elec_angle_i <= 16'($urandom);
        @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    uq_volts_i   <= uq;
    elec_angle_i <= angle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_phases.push_back(predict_phases(uq, angle, supply_mirror));
  endtask

  // Waits until every expected word has come back, then lets the pipeline run dry.
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_supply(input logic [VOLT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    supply_mirror = value;
  endtask

  // Shifted-angle sector boundary k mapped back to an input angle.
  function automatic logic [15:0] boundary_angle(int k, int offset);
    return 16'(((longint'(k) * TURN + 5) / 6) - (TURN >> 2) + offset);
  endfunction

  // Zero request, full-scale and most negative requests, and both sides of
  // every sector boundary at the reset supply.
  task automatic test_reset_supply_corners();
    send_word(16'sd0, 16'h0000);
    send_word(16'sd0, 16'hFFFF);
    send_word(16'sd32767, 16'h0000);
    send_word(-16'sd32768, 16'h1234);
    send_word(-16'sd1, 16'h8000);
    send_word(16'sd1, 16'h4000);
    send_word(16'sd2048, 16'hC000);
    send_word(-16'sd2048, 16'hAAAA);
    for (int k = 0; k < 6; k++) begin
      send_word(16'sd1536, boundary_angle(k, 0));
      send_word(16'sd1536, boundary_angle(k, -1));
    end
    settle_pipeline();
  endtask

  // With no supply every phase reads zero; any nonzero request clips.
  task automatic test_zero_supply();
    write_supply('0);
    send_word(16'sd0, 16'h2000);
    send_word(16'sd1, 16'h5555);
    send_word(-16'sd32768, 16'hFFFF);
    send_word(16'sd32767, 16'h0001);
    settle_pipeline();
  endtask

  task automatic test_supply_extremes();
    write_supply(16'd256);
    send_word(16'sd0, 16'h0000);
    send_word(16'sd147, 16'h3000);
    send_word(16'sd148, 16'h3000);
    send_word(-16'sd32768, 16'h7FFF);
    settle_pipeline();
    write_supply(16'hFFFF);
    send_word(16'sd32767, 16'h0000);
    send_word(-16'sd32768, 16'h9000);
    send_word(16'sd12345, 16'hFFFF);
    send_word(16'sd0, 16'h8001);
    settle_pipeline();
  endtask

  task automatic test_random_traffic();
    logic [VOLT_W-1:0]        supplies [8];
    logic signed [VOLT_W-1:0] uq;
    logic [15:0]              angle;
    longint                   lim;
    longint                   mag;
    int                       sel;
    supplies[0] = 16'd3072;
    supplies[1] = 16'd256;
    supplies[2] = 16'hFFFF;
    supplies[3] = 16'($urandom_range(256, 65535));
    supplies[4] = '0;
    supplies[5] = 16'($urandom_range(256, 8192));
    supplies[6] = 16'd1;
    supplies[7] = 16'($urandom_range(256, 65535));
    for (int ph = 0; ph < 8; ph++) begin
      write_supply(supplies[ph]);
      for (int n = 0; n < 200; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
          // Mostly inside the linear range for this supply.
          lim = (longint'(supply_mirror) * 5) / 8;
          if (lim > 32767) lim = 32767;
          mag = $urandom_range(0, int'(lim));
        end else if (sel < 8) begin
          mag = -1;
        end else if (sel == 8) begin
          case ($urandom_range(0, 3))
            0:       mag = 0;
            1:       mag = 32767;
            2:       mag = 1;
            default: mag = 32768;
          endcase
        end else begin
          // Around the overmodulation threshold, supply over sqrt3.
          mag = (longint'(supply_mirror) * 37) / 64 + $urandom_range(0, 16) - 8;
          if (mag < 0) mag = 0;
          if (mag > 32767) mag = 32767;
        end
        if (mag < 0) begin
          uq = VOLT_W'($urandom);
        end else if (mag == 32768) begin
          uq = -16'sd32768;
        end else begin
          uq = $urandom_range(0, 1) ? VOLT_W'(-mag) : VOLT_W'(mag);
        end
        if ($urandom_range(0, 4) == 0) begin
          angle = boundary_angle($urandom_range(0, 5), $urandom_range(0, 6) - 3);
        end else begin
          angle = 16'($urandom);
        end
        send_word(uq, angle);
        // Once per phase the sender holds back until everything has drained.
        if (n == 100) begin
          in_valid_i <= 1'b0;
          while (expected_phases.size() != 0) @(posedge clk_i);
        end
      end
      settle_pipeline();
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    uq_volts_i   <= '0;
    elec_angle_i <= '0;
    supply_mirror = SUPPLY_RESET;
    mismatch_count = 0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_supply_corners();
    test_zero_supply();
    test_supply_extremes();
    test_random_traffic();

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("tb_svpwm_phase_voltages: PASS");
    end else begin
      $display("tb_svpwm_phase_voltages: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_div.sv
rtl/core/svpwm_active_time.sv
rtl/core/svpwm_phase_voltages.sv
tb/tb_svpwm_phase_voltages.sv
